/* rtl/core/mes_pkg.sv */
// Package for the motion event segmenter: widths, reset values, register
// indices and the structs passed between the top level and the update logic.
// No dependencies.
package mes_pkg;

  localparam int INDEX_BITS  = 32;
  localparam int SAMPLE_BITS = 32;

  localparam int IDX_W   = INDEX_BITS;
  localparam int MAG_W   = SAMPLE_BITS - 1;
  localparam int THR_W   = 31;
  localparam int LIM_W   = 16;
  localparam int QCNT_W  = LIM_W + 1;
  localparam int OUT_W   = 32;
  localparam int WIDE_W  = 64;
  localparam int CMP_W   = (MAG_W > THR_W) ? MAG_W : THR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [THR_W-1:0] START_THR_RST = THR_W'(200000);
  localparam logic [THR_W-1:0] END_THR_RST   = THR_W'(650000);
  localparam logic [LIM_W-1:0] QUIET_LIM_RST = LIM_W'(40);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_THR = 2'd0,
    REG_END_THR   = 2'd1,
    REG_QUIET_LIM = 2'd2
  } mes_reg_t;

  typedef struct packed {
    logic [THR_W-1:0] start_thr;
    logic [THR_W-1:0] end_thr;
    logic [LIM_W-1:0] quiet_lim;
  } mes_cfg_t;

  typedef struct packed {
    logic              moving;
    logic [QCNT_W-1:0] quiet_count;
    logic [IDX_W-1:0]  event_start;
    logic [IDX_W-1:0]  sample_index;
    logic [OUT_W-1:0]  event_count;
  } mes_state_t;

  typedef struct packed {
    logic             emit;
    logic             has_segment;
    logic [OUT_W-1:0] seg_start;
    logic [OUT_W-1:0] seg_end;
    logic             flushed;
    logic [OUT_W-1:0] event_total;
    logic             final_res;
  } mes_result_t;

endpackage

/* rtl/core/mes_update.sv */
// Per-sample update of the segmenter: next state and result for one sample.
// Purely combinational. Depends on mes_pkg.
module mes_update (
  input  mes_pkg::mes_cfg_t               cfg,
  input  mes_pkg::mes_state_t             state,
  input  logic [mes_pkg::MAG_W-1:0]       mag,
  input  logic                            last,
  output mes_pkg::mes_state_t             state_nxt,
  output mes_pkg::mes_result_t            res
);
  import mes_pkg::*;

  logic [CMP_W-1:0]  mag_c;
  logic [CMP_W-1:0]  start_c;
  logic [CMP_W-1:0]  end_c;
  logic [WIDE_W-1:0] lim_w;
  logic [IDX_W-1:0]  lim_i;
  logic [QCNT_W-1:0] qc_inc;
  logic [IDX_W-1:0]  close_end;
  logic [IDX_W-1:0]  close_len;
  logic [IDX_W-1:0]  idx_inc;
  logic [IDX_W-1:0]  flush_end;
  logic [WIDE_W-1:0] start_w;
  logic [WIDE_W-1:0] end_w;
  logic [WIDE_W-1:0] s_start;
  logic [WIDE_W-1:0] s_end;
  logic              has;
  logic              counted;
  mes_state_t        st;

  assign mag_c     = CMP_W'(mag);
  assign start_c   = CMP_W'(cfg.start_thr);
  assign end_c     = CMP_W'(cfg.end_thr);
  assign lim_w     = WIDE_W'(cfg.quiet_lim);
  assign lim_i     = lim_w[IDX_W-1:0];
  assign qc_inc    = state.quiet_count + QCNT_W'(1);
  assign close_end = state.sample_index - lim_i;
  assign close_len = close_end - state.event_start;
  assign idx_inc   = state.sample_index + IDX_W'(1);
  // end of a flushed event, clamped at zero
  assign flush_end = (WIDE_W'(idx_inc) < lim_w) ? '0 : (idx_inc - lim_i);

  always_comb begin
    st      = state;
    has     = 1'b0;
    counted = 1'b0;
    start_w = '0;
    end_w   = '0;
    if (state.moving) begin
      if (mag_c < end_c) begin
        st.quiet_count = qc_inc;
        if (QCNT_W'(cfg.quiet_lim) < qc_inc) begin
          st.moving = 1'b0;
          if (WIDE_W'(close_len) >= lim_w) begin
            counted = 1'b1;
            has     = 1'b1;
            start_w = WIDE_W'(state.event_start);
            end_w   = WIDE_W'(close_end);
          end
        end
      end else begin
        st.quiet_count = '0;
      end
    end else if (mag_c > start_c) begin
      st.moving      = 1'b1;
      st.quiet_count = '0;
      st.event_start = state.sample_index;
    end
    if (counted && (state.event_count != '1)) begin
      st.event_count = state.event_count + OUT_W'(1);
    end
    st.sample_index = idx_inc;
  end

  always_comb begin
    s_start = start_w;
    s_end   = end_w;
    if (last && st.moving) begin
      s_start = WIDE_W'(st.event_start);
      s_end   = WIDE_W'(flush_end);
    end
  end

  always_comb begin
    res.emit        = has || last;
    res.has_segment = has || (last && st.moving);
    res.seg_start   = s_start[OUT_W-1:0];
    res.seg_end     = s_end[OUT_W-1:0];
    res.flushed     = last && st.moving;
    res.event_total = st.event_count;
    res.final_res   = last;
  end

  // the last sample of a stream returns everything to its reset values
  always_comb begin
    state_nxt = st;
    if (last) begin
      state_nxt = '0;
    end
  end

endmodule

/* rtl/core/motion_event_segmenter_unit.sv */
// Top level of the motion event segmenter: config registers, sample input
// register, stream state and result register. Depends on mes_pkg, mes_update.
//
// Usage
//   Input channel (in_valid/in_ready): one signed sample per transaction,
//   with in_stream_end marking the last sample of a stream. Samples are
//   numbered from zero within each stream.
//   Result channel (out_valid/out_ready): a transaction is issued when a
//   counted event closes, and always for the last sample of a stream
//   (final_res set, with any open event flushed). Other samples give nothing.
//   Config port: cfg_wr_en writes cfg_wdata to register cfg_index at the
//   clock edge (0 start threshold, 1 end threshold, 2 quiet limit); other
//   indices are ignored. Write only while the block is idle.
// Timing
//   One sample per cycle sustained while the receiver keeps out_ready high.
//   After the accepting edge the sample sits in the input register
//   (magnitude), then the state update loads the result register and out_valid rises if a result is emitted.
//   When the receiver stalls, one result is held in the output register and
//   one sample waits in the input register; in_ready then drops.
// Reset
//   rst_n (synchronous, active low) empties both registers, clears the
//   stream state and loads the threshold/limit reset values.
module motion_event_segmenter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [31:0]                 in_sample,
  input  logic                               in_stream_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_has_segment,
  output logic [31:0]                        out_seg_start,
  output logic [31:0]                        out_seg_end,
  output logic                               out_flushed,
  output logic [31:0]                        out_event_total,
  output logic                               out_final_res,
  input  logic                               cfg_wr_en,
  input  logic [mes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mes_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import mes_pkg::*;

  // saturating magnitude of a SAMPLE_BITS two's complement value
  function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS-1:0] neg;
    neg = ~v + SAMPLE_BITS'(1);
    if (!v[SAMPLE_BITS-1]) begin
      return v[MAG_W-1:0];
    end else if (v[MAG_W-1:0] == '0) begin
      return '1;  // most negative value saturates
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

  mes_cfg_t            cfg_r;
  mes_state_t          state_r;
  mes_state_t          state_nxt;
  mes_result_t         res;
  mes_result_t         out_r;

  logic                s1_valid_r;
  logic [MAG_W-1:0]    s1_mag_r;
  logic                s1_last_r;
  logic                out_valid_r;
  logic                advance;
  logic [WIDE_W-1:0]   raw_w;

  assign raw_w = WIDE_W'($unsigned(in_sample));

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_thr <= START_THR_RST;
      cfg_r.end_thr   <= END_THR_RST;
      cfg_r.quiet_lim <= QUIET_LIM_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_THR: cfg_r.start_thr <= cfg_wdata;
        REG_END_THR:   cfg_r.end_thr   <= cfg_wdata;
        REG_QUIET_LIM: cfg_r.quiet_lim <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // the input stage moves on when the result slot is free or being emptied
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mag_r  <= sample_mag(raw_w[SAMPLE_BITS-1:0]);
      s1_last_r <= in_stream_end;
    end
  end

  mes_update u_update (
    .cfg       (cfg_r),
    .state     (state_r),
    .mag       (s1_mag_r),
    .last      (s1_last_r),
    .state_nxt (state_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register; samples that yield nothing are dropped here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_has_segment = out_r.has_segment;
  assign out_seg_start   = out_r.seg_start;
  assign out_seg_end     = out_r.seg_end;
  assign out_flushed     = out_r.flushed;
  assign out_event_total = out_r.event_total;
  assign out_final_res   = out_r.final_res;

endmodule

/* rtl/core/mes_checker.sv */
// Port-level checks for the motion event segmenter, bound to the top level.
// Depends on motion_event_segmenter_unit.
module mes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_has_segment,
  input logic [31:0] out_seg_start,
  input logic [31:0] out_seg_end,
  input logic        out_flushed,
  input logic [31:0] out_event_total,
  input logic        out_final_res
);

  // a held result stays valid and keeps its indices and event total
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seg_start)
      && $stable(out_seg_end) && $stable(out_event_total))
    else $error("result changed while stalled");

  // a result without a segment carries zero indices
  a_empty_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_segment |-> out_seg_start == '0 && out_seg_end == '0)
    else $error("empty result with nonzero indices");

  // only the end of a stream flushes, and a flush always has a segment
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flushed |-> out_has_segment && out_final_res)
    else $error("flush outside the last result");

  // a result that is not the last one is always a counted segment
  a_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |-> out_has_segment && !out_flushed
      && out_event_total != '0)
    else $error("mid-stream result without counted segment");

  // nothing is offered in the cycle after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind motion_event_segmenter_unit mes_checker u_mes_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_has_segment (out_has_segment),
  .out_seg_start   (out_seg_start),
  .out_seg_end     (out_seg_end),
  .out_flushed     (out_flushed),
  .out_event_total (out_event_total),
  .out_final_res   (out_final_res)
);
